// File: design/lds_pkg.sv
// Shared types and codes for the LOOK disk request selector.
`timescale 1ns / 1ps

package lds_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_STORED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_CHOSEN  = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_RESP
  } lds_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;   // latch head and direction, clear the best candidates
    logic    add_wr;    // write the incoming request at the tail of the table
    logic    rd_en;     // read one table entry
    logic    rd_shift;  // the read belongs to the removal pass, not the scan
    logic    pick;      // latch the chosen entry
    logic    load_out;  // load the result register
    status_t status;    // status to load with the result
  } ctl_cmd_t;

endpackage

// File: design/lds_req_if.sv
// Request channel interface: valid, ready and the request payload.
`timescale 1ns / 1ps

interface lds_req_if #(
  parameter int TRACK_BITS = 16,
  parameter int ID_BITS    = 8
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ID_BITS-1:0]    request_id;
  logic [TRACK_BITS-1:0] dest_track;
  logic [TRACK_BITS-1:0] head_track;
  logic                  dir_up;

  modport source (
    output valid, kind, request_id, dest_track, head_track, dir_up,
    input  ready
  );

  modport sink (
    input  valid, kind, request_id, dest_track, head_track, dir_up,
    output ready
  );
endinterface

// File: design/lds_res_if.sv
// Result channel interface: valid, ready and the result payload.
`timescale 1ns / 1ps

interface lds_res_if #(
  parameter int TRACK_BITS = 16,
  parameter int ID_BITS    = 8
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [ID_BITS-1:0]    chosen_id;
  logic [TRACK_BITS-1:0] chosen_track;

  modport source (
    output valid, status, chosen_id, chosen_track,
    input  ready
  );

  modport sink (
    input  valid, status, chosen_id, chosen_track,
    output ready
  );
endinterface

// File: design/lds_datapath.sv
// Datapath: request table memory, nearest-track scan and result register.
`timescale 1ns / 1ps

module lds_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TRACK_BITS  = 16,
  parameter int ID_BITS     = 8,
  parameter int IDX_W       = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lds_pkg::ctl_cmd_t     cmd,
  input  logic [IDX_W-1:0]      rd_addr,
  input  logic [IDX_W-1:0]      add_addr,
  input  logic [ID_BITS-1:0]    in_request_id,
  input  logic [TRACK_BITS-1:0] in_dest_track,
  input  logic [TRACK_BITS-1:0] in_head_track,
  input  logic                  in_dir_up,
  output logic [IDX_W-1:0]      pick_idx,
  output logic [1:0]            out_status,
  output logic [ID_BITS-1:0]    out_chosen_id,
  output logic [TRACK_BITS-1:0] out_chosen_track
);
  import lds_pkg::*;

  localparam int WORD_W = ID_BITS + TRACK_BITS;

  // Table memory, one entry per pending request: {id, track}.
  logic [WORD_W-1:0] mem [QUEUE_DEPTH];

  logic [WORD_W-1:0]     rd_data_r;
  logic                  rd_valid_r;
  logic                  rd_shift_r;
  logic [IDX_W-1:0]      rd_addr_r;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;

  logic [TRACK_BITS-1:0] head_r;
  logic                  dir_r;

  logic                  up_found_r;
  logic [TRACK_BITS-1:0] up_dist_r;
  logic [IDX_W-1:0]      up_idx_r;
  logic [WORD_W-1:0]     up_word_r;
  logic                  dn_found_r;
  logic [TRACK_BITS-1:0] dn_dist_r;
  logic [IDX_W-1:0]      dn_idx_r;
  logic [WORD_W-1:0]     dn_word_r;

  logic [TRACK_BITS-1:0] rd_track;
  logic                  up_ok;
  logic                  dn_ok;
  logic [TRACK_BITS-1:0] up_dist;
  logic [TRACK_BITS-1:0] dn_dist;
  logic                  scan_eval;
  logic                  use_up;
  logic [WORD_W-1:0]     pick_word;

  logic [WORD_W-1:0]     chosen_word_r;
  logic [1:0]            out_status_r;
  logic [ID_BITS-1:0]    out_id_r;
  logic [TRACK_BITS-1:0] out_track_r;

  // Single write port: an add at the tail, or a one-down move during removal.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = add_addr;
    wr_data = {in_request_id, in_dest_track};
    if (cmd.add_wr) begin
      wr_en = 1'b1;
    end else if (rd_valid_r && rd_shift_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_r - IDX_W'(1);
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Read pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      rd_shift_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
      rd_shift_r <= cmd.rd_shift;
    end
  end

  // Side tests and distances for the entry just read.
  always_comb begin
    rd_track  = rd_data_r[TRACK_BITS-1:0];
    up_ok     = rd_track >= head_r;
    dn_ok     = rd_track <= head_r;
    up_dist   = rd_track - head_r;
    dn_dist   = head_r - rd_track;
    scan_eval = rd_valid_r && !rd_shift_r;
  end

  // Best candidate on each side; a strict compare keeps the earliest on a tie.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_found_r <= 1'b0;
      dn_found_r <= 1'b0;
    end else if (cmd.capture) begin
      up_found_r <= 1'b0;
      dn_found_r <= 1'b0;
    end else if (scan_eval) begin
      if (up_ok && (!up_found_r || up_dist < up_dist_r)) begin
        up_found_r <= 1'b1;
      end
      if (dn_ok && (!dn_found_r || dn_dist < dn_dist_r)) begin
        dn_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      head_r <= in_head_track;
      dir_r  <= in_dir_up;
    end
    if (scan_eval && up_ok && (!up_found_r || up_dist < up_dist_r)) begin
      up_dist_r <= up_dist;
      up_idx_r  <= rd_addr_r;
      up_word_r <= rd_data_r;
    end
    if (scan_eval && dn_ok && (!dn_found_r || dn_dist < dn_dist_r)) begin
      dn_dist_r <= dn_dist;
      dn_idx_r  <= rd_addr_r;
      dn_word_r <= rd_data_r;
    end
  end

  // Sweep side first; fall back to the other side when it holds nothing.
  always_comb begin
    use_up    = dir_r ? up_found_r : !dn_found_r;
    pick_idx  = use_up ? up_idx_r : dn_idx_r;
    pick_word = use_up ? up_word_r : dn_word_r;
  end

  // Chosen entry and result register.
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      chosen_word_r <= pick_word;
    end
    if (cmd.load_out) begin
      out_status_r <= cmd.status;
      if (cmd.status == STAT_CHOSEN) begin
        out_id_r    <= chosen_word_r[WORD_W-1:TRACK_BITS];
        out_track_r <= chosen_word_r[TRACK_BITS-1:0];
      end else begin
        out_id_r    <= '0;
        out_track_r <= '0;
      end
    end
  end

  assign out_status       = out_status_r;
  assign out_chosen_id    = out_id_r;
  assign out_chosen_track = out_track_r;

endmodule

// File: design/lds_controller.sv
// Controller: sequences add, scan, pick, removal and result hand-off.
`timescale 1ns / 1ps

module lds_controller #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX_W       = 4,
  parameter int CNT_W       = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [IDX_W-1:0]   pick_idx,
  output lds_pkg::ctl_cmd_t  cmd,
  output logic [IDX_W-1:0]   rd_addr,
  output logic [IDX_W-1:0]   add_addr
);
  import lds_pkg::*;

  lds_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;

  logic             accept;
  logic             slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign add_addr  = count_r[IDX_W-1:0];
  assign rd_addr   = idx_r[IDX_W-1:0];

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STAT_STORED;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.status    = status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              status_nxt = STAT_DROPPED;
            end else begin
              cmd.add_wr = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = STAT_STORED;
            end
            state_nxt = S_RESP;
          end else if (count_r == '0) begin
            status_nxt = STAT_EMPTY;
            state_nxt  = S_RESP;
          end else begin
            cmd.capture = 1'b1;
            idx_nxt     = '0;
            state_nxt   = S_SCAN;
          end
        end
      end

      // One entry read per cycle; the last is evaluated as the state ends.
      S_SCAN: begin
        if (idx_r < count_r) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        cmd.pick   = 1'b1;
        idx_nxt    = CNT_W'(pick_idx) + CNT_W'(1);
        status_nxt = STAT_CHOSEN;
        state_nxt  = S_SHIFT;
      end

      // Each later entry moves down by one; the last move lands as the state ends.
      S_SHIFT: begin
        if (idx_r < count_r) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_shift = 1'b1;
          idx_nxt      = idx_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("pending count above table depth");

  // A result is loaded only when the previous one has left or is leaving.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // The chosen entry lies inside the valid part of the table.
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> (CNT_W'(pick_idx) < count_r))
    else $error("chosen entry outside the table");

  // Removal only runs on a non-empty table and shrinks it by exactly one.
  a_shift_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && state_nxt == S_RESP) |=>
      (count_r == $past(count_r) - CNT_W'(1) && $past(count_r) != '0))
    else $error("removal did not shrink the table by one");
`endif

endmodule

// File: design/look_disk_request_selector_unit.sv
// Top level of the LOOK disk request selector.
// Add, or select on an empty table: the result is loaded once the output register is free.
// Select: the table is scanned one entry per cycle, the chosen entry is picked, and later
// entries move down one entry per cycle through the memory read port before the result is loaded.
// One request at a time; the next is taken once the result is in the output register.
// Synchronous active-low reset empties the table; table contents are not cleared.
`timescale 1ns / 1ps

module look_disk_request_selector_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TRACK_BITS  = 16,
  parameter int ID_BITS     = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  lds_req_if.sink   in_req,
  lds_res_if.source out_res
);
  import lds_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ctl_cmd_t         cmd;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] add_addr;
  logic [IDX_W-1:0] pick_idx;

  lds_controller #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_kind   (in_req.kind),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .pick_idx  (pick_idx),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .add_addr  (add_addr)
  );

  lds_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TRACK_BITS  (TRACK_BITS),
    .ID_BITS     (ID_BITS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .add_addr         (add_addr),
    .in_request_id    (in_req.request_id),
    .in_dest_track    (in_req.dest_track),
    .in_head_track    (in_req.head_track),
    .in_dir_up        (in_req.dir_up),
    .pick_idx         (pick_idx),
    .out_status       (out_res.status),
    .out_chosen_id    (out_res.chosen_id),
    .out_chosen_track (out_res.chosen_track)
  );

endmodule
